FILE: hw/rtl/rrfp_pkg.sv
package rrfp_pkg;

    // Fixed frame bytes.
    localparam logic [7:0] DIR_TO_HOST = 8'hD5;
    localparam logic [7:0] START_CODE2 = 8'hFF;
    localparam logic [7:0] START_ZERO  = 8'h00;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COMMAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_CAPACITY  = 2'd1;

    // Register reset values.
    localparam logic [7:0] EXPECTED_COMMAND_RST = 8'd0;
    localparam logic [7:0] BUFFER_CAPACITY_RST  = 8'd255;

    // Final frame status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    // One received byte.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_beat;

    // One parser result.
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] payload_length;
    } t_out_beat;

    // Current configuration as seen by the parser.
    typedef struct packed {
        logic [7:0] expected_command;
        logic [7:0] buffer_capacity;
    } t_cfg;

endpackage

FILE: hw/rtl/rrfp_cfg_regs.sv
module rrfp_cfg_regs
    import rrfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_command <= EXPECTED_COMMAND_RST;
            r_cfg.buffer_capacity  <= BUFFER_CAPACITY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPECTED_COMMAND: r_cfg.expected_command <= i_cfg_data;
                CFG_BUFFER_CAPACITY:  r_cfg.buffer_capacity  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/rrfp_step.sv
module rrfp_step
    import rrfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_beat  i_beat,
    input  t_cfg      i_cfg,
    output t_out_beat o_res
);

    // Parser phases.
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_START1   = 4'd1;
    localparam logic [3:0] PH_START2   = 4'd2;
    localparam logic [3:0] PH_LEN      = 4'd3;
    localparam logic [3:0] PH_LCS      = 4'd4;
    localparam logic [3:0] PH_DIR      = 4'd5;
    localparam logic [3:0] PH_RSP      = 4'd6;
    localparam logic [3:0] PH_DATA     = 4'd7;
    localparam logic [3:0] PH_DCS      = 4'd8;
    localparam logic [3:0] PH_POST     = 4'd9;
    localparam logic [3:0] PH_SKIPDATA = 4'd10;
    localparam logic [3:0] PH_SKIPDCS  = 4'd11;
    localparam logic [3:0] PH_SKIPPOST = 4'd12;

    logic [3:0] r_phase;
    logic [7:0] r_frame_length;
    logic [7:0] r_running_sum;
    logic [7:0] r_byte_count;

    logic [3:0] n_phase;
    logic [7:0] n_frame_length;
    logic [7:0] n_running_sum;
    logic [7:0] n_byte_count;

    logic [7:0] b;
    logic [7:0] plen;
    logic [7:0] count_inc;
    logic [7:0] sum_next;
    logic [3:0] cur_phase;
    t_out_beat  res;

    assign b         = i_beat.rx_byte;
    assign plen      = r_frame_length - 8'd2;
    assign count_inc = r_byte_count + 8'd1;
    assign sum_next  = r_running_sum + b;
    // A frame start byte is parsed as the first zero of a new frame.
    assign cur_phase = i_beat.frame_start ? PH_IDLE : r_phase;

    // Next state and result for the byte at hand.
    always_comb begin
        n_phase        = r_phase;
        n_frame_length = r_frame_length;
        n_running_sum  = r_running_sum;
        n_byte_count   = r_byte_count;
        res            = '0;

        if (i_beat.frame_start) begin
            if (b == START_ZERO) begin
                n_phase = PH_START1;
            end else begin
                res.done_res = 1'b1;
                res.status   = ST_INVALID;
                n_phase      = PH_IDLE;
            end
        end else begin
            case (cur_phase)
                PH_START1: begin
                    if (b == START_ZERO) begin
                        n_phase = PH_START2;
                    end else begin
                        res.done_res = 1'b1;
                        res.status   = ST_INVALID;
                        n_phase      = PH_IDLE;
                    end
                end
                PH_START2: begin
                    if (b == START_CODE2) begin
                        n_phase = PH_LEN;
                    end else begin
                        res.done_res = 1'b1;
                        res.status   = ST_INVALID;
                        n_phase      = PH_IDLE;
                    end
                end
                PH_LEN: begin
                    n_frame_length = b;
                    n_phase        = PH_LCS;
                end
                PH_LCS: begin
                    // Length checksum, and a length too short to hold D5 and RSP.
                    if ((r_frame_length + b) != 8'd0 || r_frame_length < 8'd2) begin
                        res.done_res = 1'b1;
                        res.status   = ST_INVALID;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_phase = PH_DIR;
                    end
                end
                PH_DIR: begin
                    if (b == DIR_TO_HOST) begin
                        n_phase = PH_RSP;
                    end else begin
                        res.done_res = 1'b1;
                        res.status   = ST_INVALID;
                        n_phase      = PH_IDLE;
                    end
                end
                PH_RSP: begin
                    if (b != (i_cfg.expected_command + 8'd1)) begin
                        res.done_res = 1'b1;
                        res.status   = ST_INVALID;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_running_sum = DIR_TO_HOST + b;
                        n_byte_count  = 8'd0;
                        if (plen > i_cfg.buffer_capacity) begin
                            n_phase = (plen == 8'd0) ? PH_SKIPDCS : PH_SKIPDATA;
                        end else begin
                            n_phase = (plen == 8'd0) ? PH_DCS : PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = b;
                    res.payload_index = r_byte_count;
                    n_running_sum     = sum_next;
                    n_byte_count      = count_inc;
                    if (count_inc >= plen) begin
                        n_phase = PH_DCS;
                    end
                end
                PH_DCS: begin
                    if (sum_next != 8'd0) begin
                        res.done_res = 1'b1;
                        res.status   = ST_INVALID;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_phase = PH_POST;
                    end
                end
                PH_POST: begin
                    res.done_res       = 1'b1;
                    res.status         = ST_OK;
                    res.payload_length = plen;
                    n_phase            = PH_IDLE;
                end
                PH_SKIPDATA: begin
                    n_byte_count = count_inc;
                    if (count_inc >= plen) begin
                        n_phase = PH_SKIPDCS;
                    end
                end
                PH_SKIPDCS: begin
                    n_phase = PH_SKIPPOST;
                end
                PH_SKIPPOST: begin
                    res.done_res = 1'b1;
                    res.status   = ST_NOSPACE;
                    n_phase      = PH_IDLE;
                end
                default: begin
                    // Idle bytes and unused codes leave the parser idle.
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Parser state advances once per byte handed over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_frame_length <= 8'd0;
            r_running_sum  <= 8'd0;
            r_byte_count   <= 8'd0;
        end else if (i_en) begin
            r_phase        <= n_phase;
            r_frame_length <= n_frame_length;
            r_running_sum  <= n_running_sum;
            r_byte_count   <= n_byte_count;
        end
    end

    assign o_res = res;

`ifndef SYNTHESIS
    // The phase register never holds a code beyond the skip postamble.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_SKIPPOST)
        else $error("parser phase out of range");

    // Payload bytes are only streamed with a payload index below the length.
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_byte_count < plen))
        else $error("payload index past frame length");

    // A checked response code always leads into payload, checksum or skip phases.
    a_rsp_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !i_beat.frame_start && r_phase == PH_RSP && !res.done_res) |=>
        (r_phase == PH_DATA || r_phase == PH_DCS ||
         r_phase == PH_SKIPDATA || r_phase == PH_SKIPDCS))
        else $error("bad phase after response code");
`endif

endmodule

FILE: hw/rtl/reader_response_frame_parser.sv
// Channel  Direction  Handshake                   Payload
// in       input      i_in_valid / o_in_ready     i_in_data  (t_in_beat)
// out      output     o_out_valid / i_out_ready   o_out_data (t_out_beat)
// cfg      input      i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// Every byte yields one result beat; one byte is taken per cycle while the
// output is not stalled. A byte is held in the input register, and its result
// is then registered in the result register.
// The parser step between the registers is combinational compares and adds.
// Reset is synchronous, active low, and leaves the parser idle with an empty
// pipeline; a stall on the output holds the result and, once the input
// register is also full, drops o_in_ready.
module reader_response_frame_parser
    import rrfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    logic      r_in_valid;
    t_in_beat  r_in_data;
    logic      r_out_valid;
    t_out_beat r_out_data;

    logic      advance;
    logic      in_fire;
    t_cfg      cfg;
    t_out_beat step_res;

    // The held byte moves on when the result register is free or being drained.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    rrfp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rrfp_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_beat  (r_in_data),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_data <= i_in_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // A result beat never carries a payload byte and a final status together.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.payload_valid && o_out_data.done_res))
        else $error("payload and done in one beat");

    // A non-ok status or a length appears only with done.
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK ||
                         o_out_data.payload_length != 8'd0)) |-> o_out_data.done_res)
        else $error("status without done");

    // A length is reported only on an ok frame.
    a_len_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.payload_length != 8'd0) |->
        (o_out_data.status == ST_OK))
        else $error("length on failed frame");

    // With both registers full and the output stalled, no byte is taken.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("byte taken while pipeline full");

    // A taken result is followed by a new one only if a byte was pending.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !r_in_valid) |=> !o_out_valid)
        else $error("result invented");
`endif

endmodule
